### rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BBSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define BBSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bbsf_pkg.sv
// Package for the bounded byte stream FIFO: sizes, command codes,
// controller states, result bit positions and the control/status structs.
// No dependencies.
package bbsf_pkg;

  localparam int DEPTH     = 1024;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int MAX_BURST = 64;
  localparam int FILL_W    = 11;
  localparam int COUNT_W   = 7;
  localparam int BYTE_W    = 8;
  localparam int TOTAL_W   = 64;
  localparam int CMD_W     = 3;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int IN_TW  = 16;
  localparam int OUT_TW = 168;

  localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(1024);

  // Result bit positions in the master-side tdata
  localparam int OUT_ACC_BIT   = 8;
  localparam int OUT_FILL_LSB  = 9;
  localparam int OUT_FILL_MSB  = 19;
  localparam int OUT_ENDED_BIT = 159;
  localparam int OUT_EOF_BIT   = 160;
  localparam int OUT_ERR_BIT   = 161;

  // Register word index (paddr bit 2)
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_PEEK  = 3'd1,
    CMD_POP   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_END   = 3'd4
  } cmd_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // accept the item on the slave side
    logic issue;      // read the next burst byte from the store
    logic load_byte;  // move the fetched byte into the output register
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;     // output register empty or being taken
    logic item_burst;   // presented item returns bytes
    logic rd_left_zero; // all burst reads issued
    logic rd_pend;      // fetched byte waits for the output register
  } dp_status_t;

endpackage

### rtl/bbsf_ctrl.sv
// Controller for the bounded byte stream FIFO: single-command state and
// burst sequencing. Depends on bbsf_pkg.
module bbsf_ctrl import bbsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_ctrl_t   ctrl
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && status.out_free && status.item_burst) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        if (status.rd_pend && status.out_free && status.rd_left_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready       = 1'b0;
    ctrl.take      = 1'b0;
    ctrl.issue     = 1'b0;
    ctrl.load_byte = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = status.out_free;
        ctrl.take = s_tvalid && status.out_free;
      end
      ST_BURST: begin
        ctrl.load_byte = status.rd_pend && status.out_free;
        ctrl.issue     = !status.rd_left_zero && (!status.rd_pend || ctrl.load_byte);
      end
      default: ;
    endcase
  end

endmodule

### rtl/bbsf_dp.sv
// Datapath for the bounded byte stream FIFO: byte store, pointers, counters,
// sticky flags, burst fetch and the output register. Depends on bbsf_pkg.
module bbsf_dp import bbsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [FILL_W-1:0]    capacity,
  input  logic [CMD_W-1:0]     command,
  input  logic [BYTE_W-1:0]    data_in,
  input  logic [COUNT_W-1:0]   count,
  input  dp_ctrl_t             ctrl,
  output dp_status_t           status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_TW-1:0]    m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser
);

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [BYTE_W-1:0]  mem [DEPTH];
  logic [BYTE_W-1:0]  rd_data;

  logic [ADDR_W-1:0]  head, head_next;
  logic [ADDR_W-1:0]  tail, tail_next;
  logic [FILL_W-1:0]  stored, stored_next;
  logic [TOTAL_W-1:0] written_total, written_total_next;
  logic [TOTAL_W-1:0] read_total, read_total_next;
  logic               closed, closed_next;
  logic               sticky_err, sticky_err_next;
  logic [ADDR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [COUNT_W-1:0] rd_left, rd_left_next;
  logic               rd_pend;
  logic               burst_acc, burst_acc_next;

  logic [COUNT_W-1:0] cnt_sat;
  logic [FILL_W-1:0]  cnt_ext;
  logic [FILL_W-1:0]  eff_cap;
  logic               has_room;
  logic               too_long;
  logic [COUNT_W-1:0] peek_len;
  logic [COUNT_W-1:0] burst_len;
  logic [ADDR_W:0]    head_sum;
  logic [ADDR_W-1:0]  head_adv;
  logic               mem_we;
  logic               res_acc;
  logic               item_burst;
  logic               load_single;
  logic               load;

  logic [BYTE_W-1:0]  res_byte;
  logic               res_accepted;
  logic [FILL_W-1:0]  res_space;
  logic               res_eof;
  logic [OUT_TW-1:0]  res_data;
  logic               res_last;

  // Decode the presented item
  always_comb begin
    cnt_sat  = (count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : count;
    cnt_ext  = FILL_W'(cnt_sat);
    eff_cap  = (capacity > FILL_W'(DEPTH)) ? FILL_W'(DEPTH) : capacity;
    has_room = !closed && (stored < eff_cap);
    too_long = cnt_ext > stored;
    peek_len = too_long ? COUNT_W'(stored) : cnt_sat;
    head_sum = {1'b0, head} + (ADDR_W + 1)'(cnt_sat);
    head_adv = (head_sum >= (ADDR_W + 1)'(DEPTH))
             ? ADDR_W'(head_sum - (ADDR_W + 1)'(DEPTH)) : ADDR_W'(head_sum);
    burst_len  = (command == CMD_PEEK) ? peek_len : cnt_sat;
    item_burst = ((command == CMD_PEEK) && (peek_len != '0))
              || ((command == CMD_READ) && !too_long && (cnt_sat != '0));
  end

  // Next state of the FIFO and the burst fetch
  always_comb begin
    head_next          = head;
    tail_next          = tail;
    stored_next        = stored;
    written_total_next = written_total;
    read_total_next    = read_total;
    closed_next        = closed;
    sticky_err_next    = sticky_err;
    rd_ptr_next        = rd_ptr;
    rd_left_next       = rd_left;
    burst_acc_next     = burst_acc;
    mem_we             = 1'b0;
    res_acc            = 1'b0;
    if (ctrl.take) begin
      case (command)
        CMD_WRITE: begin
          res_acc = has_room;
          if (has_room) begin
            mem_we             = 1'b1;
            tail_next          = ptr_inc(tail);
            stored_next        = stored + 1'b1;
            written_total_next = written_total + 1'b1;
          end
        end
        CMD_POP, CMD_READ: begin
          if (too_long) begin
            sticky_err_next = 1'b1;
          end else begin
            res_acc         = 1'b1;
            head_next       = head_adv;
            stored_next     = stored - cnt_ext;
            read_total_next = read_total + TOTAL_W'(cnt_sat);
          end
        end
        CMD_END: begin
          closed_next = 1'b1;
        end
        default: ;
      endcase
      if (item_burst) begin
        rd_ptr_next    = head;
        rd_left_next   = burst_len;
        burst_acc_next = (command == CMD_READ);
      end
    end
    if (ctrl.issue) begin
      rd_ptr_next  = ptr_inc(rd_ptr);
      rd_left_next = rd_left - 1'b1;
    end
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      stored        <= '0;
      written_total <= '0;
      read_total    <= '0;
      closed        <= 1'b0;
      sticky_err    <= 1'b0;
      rd_left       <= '0;
      rd_pend       <= 1'b0;
    end else begin
      head          <= head_next;
      tail          <= tail_next;
      stored        <= stored_next;
      written_total <= written_total_next;
      read_total    <= read_total_next;
      closed        <= closed_next;
      sticky_err    <= sticky_err_next;
      rd_left       <= rd_left_next;
      rd_pend       <= ctrl.issue ? 1'b1 : (ctrl.load_byte ? 1'b0 : rd_pend);
    end
  end

  // Burst pointer and result kind
  always_ff @(posedge clk) begin
    rd_ptr    <= rd_ptr_next;
    burst_acc <= burst_acc_next;
  end

  // Byte store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= data_in;
    end
  end

  // Byte store read port, held while the fetched byte waits
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Build the result; status shows the state after the whole step
  always_comb begin
    load_single  = ctrl.take && !item_burst;
    load         = load_single || ctrl.load_byte;
    res_byte     = ctrl.load_byte ? rd_data : '0;
    res_accepted = ctrl.load_byte ? burst_acc : res_acc;
    res_space    = (eff_cap > stored_next) ? eff_cap - stored_next : '0;
    res_eof      = closed_next && (stored_next == '0);
    res_last     = load_single || (rd_left == '0);
    res_data     = {6'b0, sticky_err_next, res_eof, closed_next, read_total_next,
                    written_total_next, res_space, stored_next, res_accepted, res_byte};
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= res_data;
      m_tlast <= res_last;
      m_tuser <= ctrl.load_byte;
    end
  end

  assign status.out_free     = !m_tvalid || m_tready;
  assign status.item_burst   = item_burst;
  assign status.rd_left_zero = (rd_left == '0);
  assign status.rd_pend      = rd_pend;

endmodule

### rtl/bounded_byte_stream_fifo.sv
// Top level of the bounded byte stream FIFO: APB capacity register and the
// controller/datapath pair. Depends on bbsf_pkg, bbsf_ctrl and bbsf_dp.
//
//   Channel   Direction  Signals                        Carries
//   s_*       in         s_tvalid/s_tready/s_tdata/...  one command item
//   m_*       out        m_tvalid/m_tready/m_tdata/...  one result per transfer
//   APB       in/out     psel/penable/pwrite/paddr/...  capacity register
//
// Write, pop, end and short commands: one item per cycle while the output register is free.
// Peek and read of N bytes: one byte per cycle while the master side is not stalled, each byte
// fetched through the single registered read port of the byte store.
// The output register frees the input side as soon as its result is taken.
// Reset is synchronous; the store is not cleared, no startup pass is needed.
// A stalled master side holds the current result and blocks burst fetches.
module bounded_byte_stream_fifo import bbsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,   // data_in[7:0], count[14:8], zero[15]
  input  logic [CMD_W-1:0]  s_tuser,   // command[2:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata,   // data_out[7:0], accepted[8],
                                       // fill_level[19:9], space_left[30:20],
                                       // total_written[94:31],
                                       // total_read[158:95], ended[159],
                                       // at_eof[160], error_flag[161], zero
  output logic              m_tlast,
  output logic              m_tuser,   // data_valid[0]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [FILL_W-1:0] capacity;
  logic              cap_we;
  dp_ctrl_t          ctrl;
  dp_status_t        status;

  // Capacity register, written on the APB access cycle
  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cap_we) begin
      capacity <= pwdata[FILL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_DW - FILL_W){1'b0}}, capacity} : '0;

  bbsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  bbsf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .command  (s_tuser),
    .data_in  (s_tdata[BYTE_W-1:0]),
    .count    (s_tdata[BYTE_W+COUNT_W-1:BYTE_W]),
    .ctrl     (ctrl),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### rtl/bbsf_checker.sv
// Port-level checks for the bounded byte stream FIFO, bound to the top level.
// Depends on bbsf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbsf_checker import bbsf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_TW-1:0] m_tdata,
  input logic              m_tlast
);

  logic              seen_ended;
  logic              seen_eof;
  logic [FILL_W-1:0] seen_fill;

  // Pick the flag and fill fields out of the result word
  assign seen_ended = m_tdata[OUT_ENDED_BIT];
  assign seen_eof   = m_tdata[OUT_EOF_BIT];
  assign seen_fill  = m_tdata[OUT_FILL_MSB:OUT_FILL_LSB];

  // Hold a stalled result
  `BBSF_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid, "stalled result dropped")
  `BBSF_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")

  // No new item while a burst is still delivering bytes
  `BBSF_ASSERT(a_burst_blocks, m_tvalid && !m_tlast |-> !s_tready, "item taken mid burst")

  // End of file only when empty
  `BBSF_ASSERT(a_eof_empty, m_tvalid && seen_eof |-> (seen_fill == '0), "eof with bytes stored")

  // Ended flag never falls
  `BBSF_ASSERT_NEXT(a_ended_sticky, m_tvalid && seen_ended, !m_tvalid || seen_ended, "ended cleared")

endmodule

bind bounded_byte_stream_fifo bbsf_checker u_bbsf_checker (.*);
